// File: hw/rtl/hsm_pkg.sv
// ============================================================================
// hsm_pkg
// Shared constants and types of the Horspool stream matcher: register map,
// configuration bundle and result record.
// ============================================================================
`timescale 1ns / 1ps

package hsm_pkg;

    // sizes fixed by the register map and the result format
    localparam int PAT_MAX_DEF = 16;
    localparam int PAT_BYTES   = 16;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 32;
    localparam int LEN_CFG_W   = 5;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 64;

    // register indexes, one 8-byte slot each
    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2
    } cfg_reg_t;

    // configuration as seen by the engine
    typedef struct packed {
        logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
        logic [LEN_CFG_W-1:0]             length;
        logic                             len_wr;
        logic [LEN_CFG_W-1:0]             len_wr_val;
    } cfg_t;

    // one comparison result
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
    } res_t;

endpackage

// File: hw/rtl/hsm_regs.sv
// ============================================================================
// hsm_regs
// APB-style configuration registers: pattern bytes and pattern length.
// ============================================================================
`timescale 1ns / 1ps

module hsm_regs
    import hsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [APB_DATA_W-1:0] pat_low_reg;
    logic [APB_DATA_W-1:0] pat_high_reg;
    logic [LEN_CFG_W-1:0]  length_reg;
    logic                  wr_en;
    cfg_reg_t              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = cfg_reg_t'(paddr[4:3]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            length_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PAT_LOW:  pat_low_reg  <= pwdata;
                REG_PAT_HIGH: pat_high_reg <= pwdata;
                REG_PAT_LEN:  length_reg   <= pwdata[LEN_CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_PAT_LOW:  prdata = pat_low_reg;
            REG_PAT_HIGH: prdata = pat_high_reg;
            REG_PAT_LEN:  prdata = APB_DATA_W'(length_reg);
            default:      prdata = '0;
        endcase
    end

    // configuration bundle for the engine
    assign cfg.pattern    = {pat_high_reg, pat_low_reg};
    assign cfg.length     = length_reg;
    assign cfg.len_wr     = wr_en && (reg_idx == REG_PAT_LEN);
    assign cfg.len_wr_val = pwdata[LEN_CFG_W-1:0];

endmodule

// File: hw/rtl/hsm_engine.sv
// ============================================================================
// hsm_engine
// Text window, stream counters and the sequencer that drives one byte
// comparator right to left over the current alignment.
// ============================================================================
`timescale 1ns / 1ps

module hsm_engine
    import hsm_pkg::*;
#(
    parameter int MAX_PATTERN = PAT_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CMP  = 2'b10
    } eng_state_t;

    eng_state_t        state_reg;
    logic [BYTE_W-1:0] window_reg [MAX_PATTERN];
    logic [POS_W-1:0]  seen_reg;
    logic [POS_W-1:0]  align_reg;
    logic [IDX_W-1:0]  back_reg;

    logic [LEN_W-1:0]  eff_len;
    logic              in_fire;
    logic              res_fire;
    logic              exhausted;
    logic [POS_W-1:0]  seen_inc;
    logic [POS_W-1:0]  floor_len;
    logic [POS_W-1:0]  target;
    logic [IDX_W-1:0]  pat_idx;
    logic [BYTE_W-1:0] win_byte;
    logic [BYTE_W-1:0] pat_byte;
    logic              miss;
    logic              last;
    logic [LEN_W-1:0]  bc_shift;
    logic [LEN_W-1:0]  advance;
    logic [POS_W:0]    align_sum;
    logic [POS_W-1:0]  align_adv;

    // effective length, clamped to the window depth
    always_comb
    begin
        if (cfg.length > LEN_CFG_W'(MAX_PATTERN))
            eff_len = LEN_W'(MAX_PATTERN);
        else
            eff_len = cfg.length[LEN_W-1:0];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign res_valid = (state_reg == ST_CMP);
    assign res_fire  = res_valid && res_ready;

    // alignment target for the incoming byte
    assign exhausted = (seen_reg == '1);
    assign seen_inc  = seen_reg + POS_W'(1);
    assign floor_len = (align_reg < POS_W'(eff_len)) ? POS_W'(eff_len) : align_reg;
    assign target    = (floor_len < seen_inc) ? seen_inc : floor_len;

    // shared comparator: window byte against pattern byte
    assign pat_idx  = IDX_W'(eff_len - LEN_W'(1) - LEN_W'(back_reg));
    assign win_byte = window_reg[back_reg];
    assign pat_byte = cfg.pattern[pat_idx];
    assign miss     = (win_byte != pat_byte);
    assign last     = miss || (LEN_W'(back_reg) == eff_len - LEN_W'(1));

    // bad-character distance of the newest byte, rightmost occurrence wins
    always_comb
    begin
        bc_shift = eff_len;
        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            if ((LEN_W'(i + 1) < eff_len) && (cfg.pattern[i] == window_reg[0]))
                bc_shift = eff_len - LEN_W'(1) - LEN_W'(i);
        end
    end

    // saturating alignment advance
    assign advance   = miss ? bc_shift : eff_len;
    assign align_sum = {1'b0, align_reg} + (POS_W + 1)'(advance);
    assign align_adv = align_sum[POS_W] ? '1 : align_sum[POS_W-1:0];

    assign res.pos  = seen_reg - POS_W'(back_reg);
    assign res.last = last;

    // text window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                window_reg[i] <= '0;
        end
        else if (in_fire)
        begin
            window_reg[0] <= s_tdata;
            for (int i = 1; i < MAX_PATTERN; i++)
                window_reg[i] <= window_reg[i-1];
        end
    end

    // sequencer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
            align_reg <= '0;
            back_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (!exhausted)
                        begin
                            seen_reg <= seen_inc;
                            if (eff_len != '0)
                            begin
                                align_reg <= target;
                                if (target == seen_inc)
                                begin
                                    back_reg  <= '0;
                                    state_reg <= ST_CMP;
                                end
                            end
                        end
                    end
                    else if (cfg.len_wr && (seen_reg == '0))
                    begin
                        align_reg <= POS_W'(cfg.len_wr_val);
                    end
                end
                ST_CMP:
                begin
                    if (res_fire)
                    begin
                        if (last)
                        begin
                            align_reg <= align_adv;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            back_reg <= back_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // the final result of a run always returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last result");

    // reported positions are 1-based
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.pos != '0))
        else $error("zero position reported");

    // comparison offset stays inside the pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (LEN_W'(back_reg) < eff_len))
        else $error("comparison offset beyond pattern length");

    // the byte counter never moves backward
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (seen_reg >= $past(seen_reg)))
        else $error("byte counter decreased");

endmodule

// File: hw/rtl/horspool_stream_matcher.sv
// ============================================================================
// horspool_stream_matcher
// Streaming Horspool search: text bytes in, one position per compared byte out.
// ============================================================================
// Usage:
//   s_tvalid/s_tready/s_tdata carry one text byte per transfer. Each byte
//   that lands on the current alignment end starts a right-to-left compare
//   against the configured pattern; every compared byte yields one transfer
//   on m_tvalid/m_tready with its 1-based stream position in m_tdata, and
//   m_tlast marks the last result of that byte (mismatch or full match).
//   The APB port holds pattern_low (0x00), pattern_high (0x08) and
//   pattern_length (0x10); length zero disables matching.
// Flow:
//   a byte that causes no results leaves s_tready high. A byte that starts
//   a compare holds s_tready low until its last result has been handed
//   over, comparing 1 to 16 bytes, since a single byte comparator steps
//   through the alignment; results pass through the output register.
// Reset:
//   clears the configuration registers, the window and the byte counter; no clearing pass.
// Stall:
//   with the output register full and m_tready low, the register holds and
//   the compare pauses; a new byte is taken once the compare is handed over.
// ============================================================================
`timescale 1ns / 1ps

module horspool_stream_matcher
    import hsm_pkg::*;
#(
    parameter int MAX_PATTERN = PAT_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // text input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] text_byte
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [POS_W-1:0]      m_tdata,   // [31:0] position
    output logic                  m_tlast,   // last_of_run
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    res_t res;
    logic res_valid;
    logic res_ready;
    logic out_valid_reg;
    res_t out_data_reg;

    hsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hsm_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register, refilled in the cycle its transfer completes
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.pos;
    assign m_tlast  = out_data_reg.last;

endmodule
